@@ sv/ptt_pkg.sv @@
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types and constants of the poly-X tail trim unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ptt_pkg;

	// base codes
	localparam logic [2:0] BASE_A = 3'd0;
	localparam logic [2:0] BASE_T = 3'd1;
	localparam logic [2:0] BASE_C = 3'd2;
	localparam logic [2:0] BASE_G = 3'd3;
	localparam logic [2:0] BASE_N = 3'd4;

	localparam int NBASE         = 4;
	localparam int MAX_LEN_DEF   = 4096;
	localparam int TRIM_W        = 13;
	localparam int ALLOW_CAP     = 5;   // mismatch allowance ceiling
	localparam int RATIO_SHIFT   = 3;   // one mismatch per eight bases
	localparam int STOP_SCAN_MIN = 9;
	localparam int QDEPTH        = 4;
	localparam int QPTR_W        = $clog2(QDEPTH);
	localparam int QCNT_W        = $clog2(QDEPTH + 1);

	// configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [0:0] REG_MIN_LENGTH = 1'b0;
	localparam logic [7:0] MIN_LEN_RST    = 8'd10;

	// a base after decode
	typedef struct packed {
		logic [NBASE-1:0] hit;   // exact A/T/C/G occurrence
		logic             is_n;  // counts for every base
		logic             last;
	} item_t;

endpackage

`default_nettype wire

@@ sv/ptt_front.sv @@
// ----------------------------------------------------------------------------
// ptt_front
// Accepts base beats, decodes the code and queues the result for the scanner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptt_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [2:0]    in_base,
	input  wire logic          in_last,
	output logic               q_valid,
	output ptt_pkg::item_t     q_item,
	input  wire logic          q_pop
);

	ptt_pkg::item_t                  mem_q [ptt_pkg::QDEPTH];
	logic [ptt_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [ptt_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [ptt_pkg::QCNT_W-1:0]      cnt_q;
	ptt_pkg::item_t                  dec;
	logic                            push;

	always_comb begin
		dec.hit[0] = (in_base == ptt_pkg::BASE_A);
		dec.hit[1] = (in_base == ptt_pkg::BASE_T);
		dec.hit[2] = (in_base == ptt_pkg::BASE_C);
		dec.hit[3] = (in_base == ptt_pkg::BASE_G);
		dec.is_n   = (in_base == ptt_pkg::BASE_N);
		dec.last   = in_last;
	end

	assign in_ready = (cnt_q != ptt_pkg::QCNT_W'(ptt_pkg::QDEPTH));
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != '0);
	assign q_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			priority if (push && !q_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (q_pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end else begin
				cnt_q <= cnt_q;
			end
		end
	end

endmodule

`default_nettype wire

@@ sv/ptt_back.sv @@
// ----------------------------------------------------------------------------
// ptt_back
// Per-read scan state, stop rule and the end-of-read trim result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptt_back #(
	parameter int MAX_LEN = ptt_pkg::MAX_LEN_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [7:0]                  min_length,
	input  wire logic                        q_valid,
	input  wire ptt_pkg::item_t              q_item,
	output logic                             q_pop,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [ptt_pkg::TRIM_W-1:0]       out_trim,
	output logic                             out_trimmed,
	output logic                             out_ovf
);

	localparam int CW = $clog2(MAX_LEN + 1);
	localparam int EW = (CW + 1 > 8) ? CW + 1 : 8;

	logic [CW-1:0] cnt_q  [ptt_pkg::NBASE];
	logic [CW-1:0] seen_q [ptt_pkg::NBASE];
	logic [CW-1:0] scanned_q;
	logic          stopped_q;
	logic [CW-1:0] stop_scanned_q;
	logic [CW-1:0] len_q;
	logic          ovf_q;

	logic [CW-1:0] cnt_n  [ptt_pkg::NBASE];
	logic [CW-1:0] seen_n [ptt_pkg::NBASE];
	logic [CW-1:0] scanned_n;
	logic          stopped_n;
	logic [CW-1:0] stop_scanned_n;
	logic [CW-1:0] len_n;
	logic          ovf_n;

	logic          len_full;
	logic          scan_en;
	logic [CW-1:0] shr;
	logic [CW-1:0] allowed;
	logic          all_bad;
	logic          len_ok;
	logic [EW-1:0] eff_len;
	logic          allow;
	logic [1:0]    poly;
	logic [CW-1:0] best;

	assign q_pop = q_valid && (!q_item.last || !out_valid || out_ready);

	always_comb begin
		len_full = (len_q == CW'(MAX_LEN));
		scan_en  = !len_full && !stopped_q;
		len_n    = len_full ? len_q : len_q + 1'b1;
		ovf_n    = ovf_q || len_full;

		scanned_n = scan_en ? scanned_q + 1'b1 : scanned_q;
		for (int b = 0; b < ptt_pkg::NBASE; b++) begin
			cnt_n[b]  = cnt_q[b];
			seen_n[b] = seen_q[b];
			if (scan_en && (q_item.hit[b] || q_item.is_n)) begin
				cnt_n[b] = cnt_q[b] + 1'b1;
			end
			if (scan_en && q_item.hit[b]) begin
				seen_n[b] = scanned_n;
			end
		end

		// allowance is min(5, scanned/8)
		shr     = scanned_n >> ptt_pkg::RATIO_SHIFT;
		allowed = (shr > CW'(ptt_pkg::ALLOW_CAP)) ? CW'(ptt_pkg::ALLOW_CAP) : shr;
		all_bad = 1'b1;
		for (int b = 0; b < ptt_pkg::NBASE; b++) begin
			if ((scanned_n - cnt_n[b]) <= allowed) begin
				all_bad = 1'b0;
			end
		end
		len_ok = (scanned_n >= CW'(ptt_pkg::STOP_SCAN_MIN)) ||
			(EW'(scanned_n) + EW'(1) >= EW'(min_length));

		stopped_n      = stopped_q;
		stop_scanned_n = stop_scanned_q;
		if (scan_en && all_bad && len_ok) begin
			stopped_n      = 1'b1;
			stop_scanned_n = scanned_n;
		end

		// end of read: without a stop the read counts one base longer
		eff_len = stopped_n ? EW'(stop_scanned_n) : EW'(scanned_n) + EW'(1);
		allow   = (eff_len >= EW'(min_length));

		// first maximal counter wins ties
		poly = 2'd0;
		best = cnt_n[0];
		for (int b = 1; b < ptt_pkg::NBASE; b++) begin
			if (cnt_n[b] > best) begin
				best = cnt_n[b];
				poly = 2'(b);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < ptt_pkg::NBASE; b++) begin
				cnt_q[b]  <= '0;
				seen_q[b] <= '0;
			end
			scanned_q      <= '0;
			stopped_q      <= 1'b0;
			stop_scanned_q <= '0;
			len_q          <= '0;
			ovf_q          <= 1'b0;
			out_valid      <= 1'b0;
		end else begin
			if (q_pop && q_item.last) begin
				for (int b = 0; b < ptt_pkg::NBASE; b++) begin
					cnt_q[b]  <= '0;
					seen_q[b] <= '0;
				end
				scanned_q      <= '0;
				stopped_q      <= 1'b0;
				stop_scanned_q <= '0;
				len_q          <= '0;
				ovf_q          <= 1'b0;
			end else if (q_pop) begin
				for (int b = 0; b < ptt_pkg::NBASE; b++) begin
					cnt_q[b]  <= cnt_n[b];
					seen_q[b] <= seen_n[b];
				end
				scanned_q      <= scanned_n;
				stopped_q      <= stopped_n;
				stop_scanned_q <= stop_scanned_n;
				len_q          <= len_n;
				ovf_q          <= ovf_n;
			end

			priority if (q_pop && q_item.last) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end else begin
				out_valid <= out_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_item.last) begin
			out_trim    <= allow ? ptt_pkg::TRIM_W'(seen_n[poly]) : '0;
			out_trimmed <= allow;
			out_ovf     <= ovf_n;
		end
	end

endmodule

`default_nettype wire

@@ sv/poly_x_tail_trim_unit.sv @@
// ----------------------------------------------------------------------------
// poly_x_tail_trim_unit
// Poly-X tail trimming of reads streamed base by base from the 3' end.
// ----------------------------------------------------------------------------
// Slave stream: one base per beat, s_tdata[2:0] = base code, s_tlast on the
// read's 5' end base. Master stream: one beat per read, m_tdata[12:0] = trim
// count, m_tuser[0] = trimmed, m_tuser[1] = overflow.
// APB port: min_length at address 0 (reset 10); write it only while idle.
// Throughput: one base per cycle, sustained across read boundaries. Bases are
// decoded straight into a four-entry queue; the scanner takes one queued base
// a cycle and updates its counters in that cycle.
// The result beat comes from the output register, loaded when the scanner pops
// the last base from the queue; older queued bases and a held result delay it.
// When the receiver stalls the result is held in the output register; the
// scanner keeps consuming bases of the next read and blocks only on that
// read's last base, after which the queue fills and s_tready drops.
// Reset: all counters and the queue clear, min_length returns to 10, no beat
// is presented. No clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module poly_x_tail_trim_unit #(
	parameter int MAX_LEN = ptt_pkg::MAX_LEN_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [7:0]                    s_tdata,   // [2:0] base
	input  wire logic                          s_tlast,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [15:0]                        m_tdata,   // [12:0] trim_count
	output logic [1:0]                         m_tuser,   // [0] trimmed, [1] overflow
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [ptt_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [ptt_pkg::PDATA_W-1:0]   pwdata,
	output logic [ptt_pkg::PDATA_W-1:0]        prdata,
	output logic                               pready
);

	logic                          q_valid;
	ptt_pkg::item_t                q_item;
	logic                          q_pop;
	logic [7:0]                    min_length_q;
	logic [ptt_pkg::TRIM_W-1:0]    trim;
	logic                          trimmed;
	logic                          ovf;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == ptt_pkg::REG_MIN_LENGTH) ?
		ptt_pkg::PDATA_W'(min_length_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_length_q <= ptt_pkg::MIN_LEN_RST;
		end else if (psel && penable && pwrite && pready &&
				(paddr[2] == ptt_pkg::REG_MIN_LENGTH)) begin
			min_length_q <= pwdata[7:0];
		end
	end

	ptt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_base  (s_tdata[2:0]),
		.in_last  (s_tlast),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	ptt_back #(
		.MAX_LEN (MAX_LEN)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.min_length  (min_length_q),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_trim    (trim),
		.out_trimmed (trimmed),
		.out_ovf     (ovf)
	);

	assign m_tdata = 16'(trim);
	assign m_tuser = {ovf, trimmed};

	// a result only follows the scanner taking a read's last base
	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(q_pop && q_item.last))
		else $error("result beat without a closing base");

	// a blocked length check never trims
	a_untrimmed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata[12:0] == '0))
		else $error("trim count set on untrimmed read");

	// a full queue always has a base on offer to the scanner
	a_full_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> q_valid)
		else $error("input stalled with empty queue");

endmodule

`default_nettype wire

@@ dv/tb_poly_x_tail_trim_unit.sv @@
// ----------------------------------------------------------------------------
// tb_poly_x_tail_trim_unit
// Self-checking bench for the poly-X tail trim unit. Reads are streamed base
// by base from a queue, a local model predicts each read's trim beat and the
// output monitor checks it. min_length is changed over the APB port between
// phases, and both stream sides idle at random, with one long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_poly_x_tail_trim_unit;
	import ptt_pkg::*;

	localparam int MAX_BASES  = 4096;
	localparam int MIS_RATIO  = 8;    // one mismatch allowed per eight bases
	localparam int MIS_CAP    = 5;
	localparam int STOP_MIN   = 9;
	localparam int CYCLE_CAP  = 2000000;
	localparam int HOLD_LEN   = 400;
	localparam int DRAIN_WAIT = 8;

	localparam logic [2:0] BASE_OTHER = 3'd5;
	localparam logic [2:0] BASE_RSV6  = 3'd6;
	localparam logic [2:0] BASE_RSV7  = 3'd7;

	localparam logic [PADDR_W-1:0] ADDR_MIN_LEN = PADDR_W'(4 * REG_MIN_LENGTH);
	localparam logic [PADDR_W-1:0] ADDR_UNMAPPED = PADDR_W'(4);

	typedef struct packed {
		logic [2:0] code;
		logic       last;
	} base_beat_t;

	typedef struct packed {
		logic [TRIM_W-1:0] trim;
		logic              trimmed;
		logic              ovf;
	} trim_res_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [7:0] s_tdata;   // [2:0] base, rest zero
	logic s_tlast;
	logic m_tvalid;
	logic m_tready;
	logic [15:0] m_tdata;  // [12:0] trim_count
	logic [1:0] m_tuser;   // [0] trimmed, [1] overflow
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	poly_x_tail_trim_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// bench state
	base_beat_t beat_q[$];
	trim_res_t  trim_due_q[$];
	base_beat_t nxt_beat;
	trim_res_t  got_res;
	trim_res_t  want_res;
	int  bases_queued = 0;
	int  bases_taken = 0;
	int  errors = 0;
	int  cycles = 0;
	int  src_gap;
	int  snk_stall;
	int  hold_left;
	int  hold_req = 0;
	int  hold_seen;
	bit  src_idle = 1'b1;
	bit  snk_idle = 1'b1;

	// model of the trimmer
	logic [7:0]        mdl_min_len;
	logic [TRIM_W-1:0] mdl_cnt[NBASE];
	logic [TRIM_W-1:0] mdl_seen[NBASE];
	logic [TRIM_W-1:0] mdl_scanned;
	logic              mdl_halted;
	logic [TRIM_W-1:0] mdl_halt_at;
	logic [TRIM_W-1:0] mdl_recv;
	logic              mdl_ovf;

	function automatic void clear_read_state();
		for (int b = 0; b < NBASE; b++) begin
			mdl_cnt[b] = '0;
			mdl_seen[b] = '0;
		end
		mdl_scanned = '0;
		mdl_halted = 1'b0;
		mdl_halt_at = '0;
		mdl_recv = '0;
		mdl_ovf = 1'b0;
	endfunction

	function automatic void scan_one(logic [2:0] code);
		int lim;
		int n;
		bit none_fit;
		none_fit = 1'b1;
		if (code < NBASE) begin
			mdl_cnt[code] = mdl_cnt[code] + 1'b1;
			mdl_seen[code] = mdl_scanned + 1'b1;
		end else if (code == BASE_N) begin
			for (int b = 0; b < NBASE; b++)
				mdl_cnt[b] = mdl_cnt[b] + 1'b1;
		end
		mdl_scanned = mdl_scanned + 1'b1;
		n = mdl_scanned;
		lim = n / MIS_RATIO;
		if (lim > MIS_CAP)
			lim = MIS_CAP;
		for (int b = 0; b < NBASE; b++)
			if (n - int'(mdl_cnt[b]) <= lim)
				none_fit = 1'b0;
		if (none_fit && (n >= STOP_MIN || n + 1 >= int'(mdl_min_len))) begin
			mdl_halted = 1'b1;
			mdl_halt_at = mdl_scanned;
		end
	endfunction

	// one accepted base; a read's last base queues its trim result
	function automatic void polytail_predict(logic [2:0] code, logic is_last);
		int eff;
		int poly;
		trim_res_t r;
		if (mdl_recv >= MAX_BASES) begin
			mdl_ovf = 1'b1;
		end else begin
			mdl_recv = mdl_recv + 1'b1;
			if (!mdl_halted)
				scan_one(code);
		end
		if (is_last) begin
			r = '0;
			eff = mdl_halted ? int'(mdl_halt_at) : int'(mdl_scanned) + 1;
			if (eff >= int'(mdl_min_len)) begin
				r.trimmed = 1'b1;
				poly = 0;
				for (int b = 1; b < NBASE; b++)
					if (mdl_cnt[b] > mdl_cnt[poly])
						poly = b;
				r.trim = mdl_seen[poly];
			end
			r.ovf = mdl_ovf;
			trim_due_q.push_back(r);
			clear_read_state();
		end
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 2);
		else if (r < 95)
			return $urandom_range(3, 8);
		return $urandom_range(20, 80);
	endfunction

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("tb: failure");
			$finish;
		end
	end

	// input driver; the model is fed on every accepted beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tlast <= 1'b0;
			src_gap = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				polytail_predict(s_tdata[2:0], s_tlast);
				bases_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (src_gap != 0) begin
					src_gap--;
					s_tvalid <= 1'b0;
				end else if (beat_q.size() != 0) begin
					nxt_beat = beat_q.pop_front();
					s_tdata <= {5'b0, nxt_beat.code};
					s_tlast <= nxt_beat.last;
					s_tvalid <= 1'b1;
					src_gap = (src_idle && $urandom_range(0, 2) == 0) ? idle_len() : 0;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// output ready: random stalls, plus a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			snk_stall = 0;
			hold_left = 0;
			hold_seen = 0;
		end else if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = HOLD_LEN;
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (snk_stall != 0) begin
			snk_stall--;
			m_tready <= 1'b0;
		end else if (snk_idle && $urandom_range(0, 3) == 0) begin
			snk_stall = idle_len() - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_res.trim = m_tdata[TRIM_W-1:0];
			got_res.trimmed = m_tuser[0];
			got_res.ovf = m_tuser[1];
			if (trim_due_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result trim=%0d trimmed=%0d ovf=%0d", $time,
					got_res.trim, got_res.trimmed, got_res.ovf);
			end else begin
				want_res = trim_due_q.pop_front();
				if (got_res.trim !== want_res.trim) begin
					errors++;
					$display("%0t: trim_count exp %0d got %0d", $time, want_res.trim,
						got_res.trim);
				end
				if (got_res.trimmed !== want_res.trimmed) begin
					errors++;
					$display("%0t: trimmed exp %0d got %0d", $time, want_res.trimmed,
						got_res.trimmed);
				end
				if (got_res.ovf !== want_res.ovf) begin
					errors++;
					$display("%0t: overflow exp %0d got %0d", $time, want_res.ovf,
						got_res.ovf);
				end
			end
		end
	end

	task automatic apb_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_MIN_LEN)
			mdl_min_len = data[7:0];
	endtask

	task automatic push_base(logic [2:0] code, logic is_last);
		base_beat_t b;
		b.code = code;
		b.last = is_last;
		beat_q.push_back(b);
		bases_queued++;
	endtask

	task automatic push_run(logic [2:0] code, int n);
		for (int i = 0; i < n; i++)
			push_base(code, i == n - 1);
	endtask

	// mostly a noisy poly tail followed by random bases; some pure noise
	task automatic push_read();
		int len;
		int tail;
		int r;
		logic [2:0] poly;
		logic [2:0] c;
		r = $urandom_range(0, 99);
		if (r < 10)
			len = $urandom_range(1, 3);
		else if (r < 90)
			len = $urandom_range(4, 30);
		else
			len = $urandom_range(31, 80);
		poly = 3'($urandom_range(0, NBASE - 1));
		tail = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, len);
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(0, 99);
			if (i < tail && r < 88)
				c = poly;
			else if (i < tail && r < 93)
				c = BASE_N;
			else
				c = 3'($urandom_range(0, 7));
			push_base(c, i == len - 1);
		end
	endtask

	task automatic push_reads(int n_bases);
		int goal;
		goal = bases_queued + n_bases;
		while (bases_queued < goal)
			push_read();
	endtask

	task automatic drain();
		while (bases_taken != bases_queued || trim_due_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic set_idling(bit src, bit snk);
		@(posedge clk);
		src_idle <= src;
		snk_idle <= snk;
	endtask

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		mdl_min_len = MIN_LEN_RST;
		clear_read_state();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset value of min_length
		push_base(BASE_A, 1'b1);
		push_base(BASE_RSV6, 1'b0);
		push_base(BASE_RSV7, 1'b0);
		push_base(BASE_OTHER, 1'b1);
		// eight A then C C: scan stops at ten, trailing G ignored
		for (int i = 0; i < 8; i++)
			push_base(BASE_A, 1'b0);
		push_base(BASE_C, 1'b0);
		push_base(BASE_C, 1'b0);
		push_base(BASE_G, 1'b0);
		push_base(BASE_T, 1'b1);
		push_reads(120);
		drain();

		// no length limit: poly base never seen still counts as trimmed
		apb_write(ADDR_MIN_LEN, 32'd0);
		push_base(BASE_N, 1'b0);
		push_base(BASE_N, 1'b0);
		push_base(BASE_N, 1'b1);
		drain();
		// back-pressure: output held while the input streams without gaps
		set_idling(1'b0, 1'b1);
		hold_req <= hold_req + 1;
		push_reads(100);
		drain();

		set_idling(1'b0, 1'b0);
		apb_write(ADDR_MIN_LEN, 32'd255);
		push_reads(60);
		push_run(BASE_A, 40);
		push_run(BASE_T, 43);
		drain();
		set_idling(1'b1, 1'b1);
		push_reads(60);
		drain();

		apb_write(ADDR_MIN_LEN, 32'd1);
		push_reads(100);
		drain();

		apb_write(ADDR_UNMAPPED, 32'($urandom));
		push_reads(40);
		drain();
		apb_write(ADDR_MIN_LEN, 32'($urandom_range(2, 40)));
		push_reads(100);
		drain();

		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

@@ sim.f @@
sv/ptt_pkg.sv
sv/ptt_front.sv
sv/ptt_back.sv
sv/poly_x_tail_trim_unit.sv
dv/tb_poly_x_tail_trim_unit.sv
